FILE: hdl/lrsc_pkg.sv
package lrsc_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_FLUSH  = 2'd1;
  localparam logic [1:0] REQ_RESET  = 2'd2;

  // Result actions carried on out_tuser
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_HIT   = 3'd1;
  localparam logic [2:0] ACT_LOAD  = 3'd2;
  localparam logic [2:0] ACT_EVICT = 3'd3;
  localparam logic [2:0] ACT_FLUSH = 3'd4;

  // Fixed field widths
  localparam int REQ_W    = 2;
  localparam int GREG_W   = 5;
  localparam int ACT_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int IN_DW    = 8;
  localparam int OUT_DW   = 16;

  // One result transaction
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
    logic [GREG_W-1:0] store_reg;
    logic [GREG_W-1:0] load_reg;
    logic              last;
  } res_t;

endpackage

FILE: hdl/lru_register_slot_cache.sv
// Fully associative register-slot cache with LRU replacement. SLOTS host slots
// each hold one guest register and an AGE_BITS saturating age. One compare and
// age-update unit walks the slots one per cycle, unless a full output register
// holds the walk. An access scans every slot and then commits its result; a
// flush gives one result per occupied slot, or a single ACT_NONE result when
// no slot is occupied; reset and unknown requests give one ACT_NONE result. The
// block takes no new request while one is in progress; a finished result sits
// in an output register, and a full output register holds the commit and the
// flush walk at occupied slots.
module lru_register_slot_cache
  import lrsc_pkg::*;
#(
  parameter int SLOTS    = 10,
  parameter int AGE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,    // guest_reg
  input  logic [REQ_W-1:0]  in_tuser,    // req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,   // slot, store_reg, load_reg
  output logic [ACT_W-1:0]  out_tuser,   // action
  output logic              out_tlast
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  // Slot storage
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [GREG_W-1:0]   guest_r [SLOTS];
  logic [AGE_BITS-1:0] age_r   [SLOTS];

  // Sequencer state
  logic [2:0]          state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [GREG_W-1:0]   greg_r, greg_nxt;
  logic [AGE_BITS-1:0] oldest_r, oldest_nxt;
  logic [IW-1:0]       victim_r, victim_nxt;
  logic [GREG_W-1:0]   vguest_r, vguest_nxt;
  logic                hit_r, hit_nxt;
  logic [IW-1:0]       hit_idx_r, hit_idx_nxt;
  logic                emp_r, emp_nxt;
  logic [IW-1:0]       emp_idx_r, emp_idx_nxt;
  logic                any_r, any_nxt;

  // Storage write port
  logic                age_we, guest_we;
  logic [IW-1:0]       wr_idx;
  logic [AGE_BITS-1:0] wr_age;
  logic [GREG_W-1:0]   wr_guest;

  logic                ld, free;
  res_t                res;
  logic [AGE_BITS-1:0] cur_age, aged;
  logic [GREG_W-1:0]   cur_guest;
  logic [SLOTS-1:0]    idx_hot;

  assign in_tready = (state_r == ST_IDLE);

  // Shared unit: saturating age, read at the walk index
  assign cur_age   = age_r[idx_r];
  assign cur_guest = guest_r[idx_r];
  assign aged      = (cur_age == {AGE_BITS{1'b1}}) ? cur_age : cur_age + 1'b1;
  assign idx_hot   = SLOTS'(1) << idx_r;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    greg_nxt    = greg_r;
    oldest_nxt  = oldest_r;
    victim_nxt  = victim_r;
    vguest_nxt  = vguest_r;
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    emp_nxt     = emp_r;
    emp_idx_nxt = emp_idx_r;
    any_nxt     = any_r;
    valid_nxt   = valid_r;
    age_we      = 1'b0;
    guest_we    = 1'b0;
    wr_idx      = idx_r;
    wr_age      = '0;
    wr_guest    = greg_r;
    ld          = 1'b0;
    res         = '0;
    res.action  = ACT_NONE;
    res.last    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          idx_nxt = '0;
          case (in_tuser)
            REQ_ACCESS: begin
              state_nxt  = ST_SCAN;
              greg_nxt   = in_tdata[GREG_W-1:0];
              oldest_nxt = '0;
              victim_nxt = '0;
              hit_nxt    = 1'b0;
              emp_nxt    = 1'b0;
            end
            REQ_FLUSH: begin
              state_nxt = ST_FLUSH;
              any_nxt   = |valid_r;
            end
            REQ_RESET: begin
              state_nxt = ST_NONE;
              valid_nxt = '0;
            end
            default: begin
              state_nxt = ST_NONE;
            end
          endcase
        end
      end

      // Age each slot, track oldest, first hit and first empty
      ST_SCAN: begin
        age_we = 1'b1;
        wr_age = aged;
        if (aged > oldest_r) begin
          oldest_nxt = aged;
          victim_nxt = idx_r;
          vguest_nxt = cur_guest;
        end
        if (!hit_r && valid_r[idx_r] && cur_guest == greg_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r;
        end
        if (!emp_r && !valid_r[idx_r]) begin
          emp_nxt     = 1'b1;
          emp_idx_nxt = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Commit hit, fill or eviction
      ST_FIN: begin
        if (free) begin
          ld        = 1'b1;
          age_we    = 1'b1;
          state_nxt = ST_IDLE;
          if (hit_r) begin
            wr_idx     = hit_idx_r;
            res.action = ACT_HIT;
            res.slot   = SLOT_W'(hit_idx_r);
          end else if (emp_r) begin
            wr_idx     = emp_idx_r;
            guest_we   = 1'b1;
            valid_nxt[emp_idx_r] = 1'b1;
            res.action   = ACT_LOAD;
            res.slot     = SLOT_W'(emp_idx_r);
            res.load_reg = greg_r;
          end else begin
            wr_idx        = victim_r;
            guest_we      = 1'b1;
            res.action    = ACT_EVICT;
            res.slot      = SLOT_W'(victim_r);
            res.store_reg = vguest_r;
            res.load_reg  = greg_r;
          end
        end
      end

      // Write back occupied slots in index order
      ST_FLUSH: begin
        if (!any_r) begin
          if (free) begin
            ld        = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (!valid_r[idx_r] || free) begin
          if (valid_r[idx_r]) begin
            ld            = 1'b1;
            age_we        = 1'b1;
            valid_nxt[idx_r] = 1'b0;
            res.action    = ACT_FLUSH;
            res.slot      = SLOT_W'(idx_r);
            res.store_reg = cur_guest;
            // lower slots are already cleared
            res.last      = ((valid_r & ~idx_hot) == '0);
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_NONE: begin
        if (free) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      idx_r   <= '0;
      hit_r   <= 1'b0;
      emp_r   <= 1'b0;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      hit_r   <= hit_nxt;
      emp_r   <= emp_nxt;
      any_r   <= any_nxt;
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    greg_r    <= greg_nxt;
    oldest_r  <= oldest_nxt;
    victim_r  <= victim_nxt;
    vguest_r  <= vguest_nxt;
    hit_idx_r <= hit_idx_nxt;
    emp_idx_r <= emp_idx_nxt;
  end

  // Slot storage; contents of empty slots are never observed
  always_ff @(posedge clk) begin
    if (age_we) begin
      age_r[wr_idx] <= wr_age;
    end
    if (guest_we) begin
      guest_r[wr_idx] <= wr_guest;
    end
  end

  lrsc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hdl/lrsc_out_reg.sv
module lrsc_out_reg
  import lrsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  res_t              res,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,   // slot, store_reg, load_reg
  output logic [ACT_W-1:0]  out_tuser,   // action
  output logic              out_tlast
);

  logic valid_r;
  res_t res_r;

  // Holding register is free when empty or being drained this cycle
  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.action;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {{(OUT_DW - SLOT_W - 2*GREG_W){1'b0}},
                       res_r.load_reg, res_r.store_reg, res_r.slot};

endmodule
